@@ src/i2c_master_bit_engine_core_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CMBE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CMBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/i2cmbe_pkg.sv @@
package i2cmbe_pkg;

   localparam logic [2:0] MODE_NONE  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_STOP  = 3'd2;
   localparam logic [2:0] MODE_WRITE = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;

   localparam logic REG_TICKS_PER_UNIT = 1'b0;
   localparam logic REG_ACK_TIMEOUT    = 1'b1;

   localparam logic [9:0]  TICKS_PER_UNIT_RESET = 10'd1;
   localparam logic [15:0] ACK_TIMEOUT_RESET    = 16'd250;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_missing;
   } res_type;

   typedef struct packed {
      logic [9:0]  ticks_per_unit;
      logic [15:0] ack_timeout;
   } cfg_type;

endpackage

@@ src/i2cmbe_csr.sv @@
module i2cmbe_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output i2cmbe_pkg::cfg_type cfg
);

   logic [9:0]  tpu_ff;
   logic [9:0]  tpu_in;
   logic [15:0] timeout_ff;
   logic [15:0] timeout_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      tpu_in     = tpu_ff;
      timeout_in = timeout_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            i2cmbe_pkg::REG_TICKS_PER_UNIT: tpu_in     = csr_pwdata[9:0];
            i2cmbe_pkg::REG_ACK_TIMEOUT:    timeout_in = csr_pwdata[15:0];
            default:                        tpu_in     = tpu_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff     <= i2cmbe_pkg::TICKS_PER_UNIT_RESET;
         timeout_ff <= i2cmbe_pkg::ACK_TIMEOUT_RESET;
      end else begin
         tpu_ff     <= tpu_in;
         timeout_ff <= timeout_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         i2cmbe_pkg::REG_TICKS_PER_UNIT: csr_prdata = {22'd0, tpu_ff};
         i2cmbe_pkg::REG_ACK_TIMEOUT:    csr_prdata = {16'd0, timeout_ff};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   assign cfg.ticks_per_unit = tpu_ff;
   assign cfg.ack_timeout    = timeout_ff;

endmodule

@@ src/i2cmbe_engine.sv @@
module i2cmbe_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  i2cmbe_pkg::req_type req,
   input  i2cmbe_pkg::cfg_type cfg,
   output i2cmbe_pkg::res_type res
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_SP_A, PH_SP_B,
      PH_WR_D, PH_WR_H, PH_WR_L, PH_AK_R, PH_AK_H, PH_AK_P,
      PH_RD_L, PH_RD_H, PH_RA_D, PH_RA_H, PH_RA_L
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [9:0]  unit_ff, unit_in;
   logic [2:0]  units_left_ff, units_left_in;
   logic [15:0] poll_ff, poll_in;
   logic        ack_choice_ff, ack_choice_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic [7:0]  rx_hold_ff, rx_hold_in;
   logic        nack_ff, nack_in;
   logic        done;
   logic [2:0]  step_len;
   logic [9:0]  tpu;

   assign tpu = (cfg.ticks_per_unit == 10'd0) ? 10'd1 : cfg.ticks_per_unit;

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      unit_in       = unit_ff;
      units_left_in = units_left_ff;
      poll_in       = poll_ff;
      ack_choice_in = ack_choice_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      rx_hold_in    = rx_hold_ff;
      nack_in       = nack_ff;
      done          = 1'b0;
      step_len      = 3'd0;

      if (phase_in == PH_IDLE) begin
         unique case (req.mode)
            i2cmbe_pkg::MODE_START: begin
               phase_in = PH_ST_A;
            end
            i2cmbe_pkg::MODE_STOP: begin
               phase_in = PH_SP_A;
            end
            i2cmbe_pkg::MODE_WRITE: begin
               shift_in = req.tx_byte;
               phase_in = PH_WR_D;
            end
            i2cmbe_pkg::MODE_READ: begin
               shift_in      = 8'd0;
               ack_choice_in = req.send_ack;
               phase_in      = PH_RD_L;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         if (phase_in != PH_IDLE) begin
            bit_count_in  = 3'd0;
            unit_in       = 10'd0;
            units_left_in = 3'd0;
         end
      end

      if (phase_in == PH_AK_P) begin
         if (!req.sda_in) begin
            scl_in   = 1'b0;
            nack_in  = 1'b0;
            phase_in = PH_IDLE;
            done     = 1'b1;
         end else if (poll_in >= cfg.ack_timeout) begin
            nack_in       = 1'b1;
            phase_in      = PH_SP_A;
            units_left_in = 3'd0;
            unit_in       = 10'd0;
         end else begin
            poll_in = poll_in + 16'd1;
         end
      end else if (phase_in != PH_IDLE) begin
         if (units_left_in == 3'd0) begin
            unique case (phase_in)
               PH_ST_A: begin scl_in = 1'b1; sda_in = 1'b1; step_len = 3'd4; end
               PH_ST_B: begin sda_in = 1'b0; step_len = 3'd4; end
               PH_ST_C: begin scl_in = 1'b0; step_len = 3'd0; end
               PH_SP_A: begin scl_in = 1'b0; sda_in = 1'b0; step_len = 3'd4; end
               PH_SP_B: begin scl_in = 1'b1; sda_in = 1'b1; step_len = 3'd4; end
               PH_WR_D: begin sda_in = shift_in[7]; step_len = 3'd2; end
               PH_WR_H: begin scl_in = 1'b1; step_len = 3'd2; end
               PH_WR_L: begin scl_in = 1'b0; step_len = 3'd2; end
               PH_AK_R: begin sda_in = 1'b1; step_len = 3'd1; end
               PH_AK_H: begin scl_in = 1'b1; step_len = 3'd1; end
               PH_RD_L: begin scl_in = 1'b0; sda_in = 1'b1; step_len = 3'd2; end
               PH_RD_H: begin
                  scl_in   = 1'b1;
                  shift_in = {shift_in[6:0], req.sda_in};
                  step_len = 3'd1;
               end
               PH_RA_D: begin
                  scl_in   = 1'b0;
                  sda_in   = !ack_choice_in;
                  step_len = 3'd2;
               end
               PH_RA_H: begin scl_in = 1'b1; step_len = 3'd2; end
               default: begin scl_in = 1'b0; step_len = 3'd0; end
            endcase
            units_left_in = step_len;
            unit_in       = 10'd0;
         end
         if (units_left_in != 3'd0) begin
            unit_in = unit_in + 10'd1;
            if (unit_in >= tpu) begin
               unit_in       = 10'd0;
               units_left_in = units_left_in - 3'd1;
            end
         end
         if (units_left_in == 3'd0) begin
            unique case (phase_in)
               PH_ST_A: phase_in = PH_ST_B;
               PH_ST_B: phase_in = PH_ST_C;
               PH_SP_A: phase_in = PH_SP_B;
               PH_WR_D: phase_in = PH_WR_H;
               PH_WR_H: phase_in = PH_WR_L;
               PH_WR_L: begin
                  shift_in     = {shift_in[6:0], 1'b0};
                  bit_count_in = bit_count_in + 3'd1;
                  phase_in     = (bit_count_in == 3'd0) ? PH_AK_R : PH_WR_D;
               end
               PH_AK_R: phase_in = PH_AK_H;
               PH_AK_H: begin
                  phase_in = PH_AK_P;
                  poll_in  = 16'd0;
               end
               PH_RD_L: phase_in = PH_RD_H;
               PH_RD_H: begin
                  bit_count_in = bit_count_in + 3'd1;
                  phase_in     = (bit_count_in == 3'd0) ? PH_RA_D : PH_RD_L;
               end
               PH_RA_D: phase_in = PH_RA_H;
               PH_RA_H: phase_in = PH_RA_L;
               PH_RA_L: begin
                  rx_hold_in = shift_in;
                  phase_in   = PH_IDLE;
                  done       = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= 3'd0;
         shift_ff      <= 8'd0;
         unit_ff       <= 10'd0;
         units_left_ff <= 3'd0;
         poll_ff       <= 16'd0;
         ack_choice_ff <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         rx_hold_ff    <= 8'd0;
         nack_ff       <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         unit_ff       <= unit_in;
         units_left_ff <= units_left_in;
         poll_ff       <= poll_in;
         ack_choice_ff <= ack_choice_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         rx_hold_ff    <= rx_hold_in;
         nack_ff       <= nack_in;
      end
   end

   assign res.scl_out     = scl_in;
   assign res.sda_out     = sda_in;
   assign res.busy_res    = (phase_in != PH_IDLE);
   assign res.done_res    = done;
   assign res.rx_byte     = rx_hold_in;
   assign res.ack_missing = nack_in;

endmodule

@@ src/i2c_master_bit_engine_core.sv @@
// I2C master bit engine. Each accepted req word is one timing tick: the engine
// starts a command (start, stop, write byte with acknowledge poll, read byte
// answered with ack or nack) when it is idle and returns one rsp word per tick
// with the SCL and SDA drive levels, busy, a done pulse, the last received
// byte and the missing-acknowledge flag. One word is accepted every clock
// cycle unless a stalled rsp word holds the input; each word goes through the
// req input register and the combinational sequencer step to the rsp register.
// Registers: ticks_per_unit at byte address 0, ack_timeout at byte address 4;
// write them only while no tick is in flight.
`include "i2c_master_bit_engine_core_macros.svh"

module i2c_master_bit_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_send_ack,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_missing,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                in_valid_ff, in_valid_in;
   i2cmbe_pkg::req_type in_word_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   i2cmbe_pkg::res_type rsp_word_ff;
   i2cmbe_pkg::res_type step_res;
   i2cmbe_pkg::cfg_type cfg;
   logic                advance;

   i2cmbe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   i2cmbe_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_word_ff),
      .cfg     (cfg),
      .res     (step_res)
   );

   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & ~req_stall) begin
         in_word_ff.mode     <= req_mode;
         in_word_ff.tx_byte  <= req_tx_byte;
         in_word_ff.send_ack <= req_send_ack;
         in_word_ff.sda_in   <= req_sda_in;
      end
      if (advance) begin
         rsp_word_ff <= step_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_out     = rsp_word_ff.scl_out;
   assign rsp_sda_out     = rsp_word_ff.sda_out;
   assign rsp_busy_res    = rsp_word_ff.busy_res;
   assign rsp_done_res    = rsp_word_ff.done_res;
   assign rsp_rx_byte     = rsp_word_ff.rx_byte;
   assign rsp_ack_missing = rsp_word_ff.ack_missing;

   `I2CMBE_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall,
      in_valid_ff && rsp_valid_ff && rsp_stall, "input stalled without a full pipeline")
   `I2CMBE_ASSERT_SAME(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res,
      !rsp_busy_res, "completed command still reported busy")
   `I2CMBE_ASSERT_NEXT(a_drain, clock, reset, rsp_valid && !rsp_stall && !in_valid_ff,
      !rsp_valid, "result word appeared without an input word")

endmodule
